// ----- hw/rtl/msnco_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msnco_pkg
// Shared widths, register indexes and the configuration bundle for the
// multichannel sawtooth oscillator.
// ----------------------------------------------------------------------------
package msnco_pkg;

    // field widths
    localparam int unsigned CH_W       = 3;
    localparam int unsigned FREQ_W     = 32;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 4;

    // fraction bits of the frequency input
    localparam int unsigned FREQ_FRAC = 12;

    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes
    localparam cfg_index_t REG_CHANNEL_COUNT  = 4'd0;
    localparam cfg_index_t REG_CHANNEL_OFFSET = 4'd1;
    localparam cfg_index_t REG_RATE_SCALE     = 4'd2;
    localparam cfg_index_t REG_BIPOLAR_MODE   = 4'd3;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT  = 4'd2;
    localparam logic [PHASE_W-1:0] RST_CHANNEL_OFFSET = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] RST_RATE_SCALE     = 32'd89478;
    localparam logic               RST_BIPOLAR_MODE   = 1'b1;

    // bipolar output midpoint in Q1.23
    localparam logic [SAMPLE_W-1:0] BIPOLAR_BIAS = 24'h80_0000;

    // decoded configuration seen by the datapath
    typedef struct packed {
        logic [COUNT_W-1:0] last_ch;
        logic [PHASE_W-1:0] offset_step;
        logic [PHASE_W-1:0] rate_scale;
        logic               bipolar;
    } cfg_t;

endpackage : msnco_pkg
`default_nettype wire

// ----- hw/rtl/msnco_acc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msnco_acc_ram
// Phase accumulator store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module msnco_acc_ram #(
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [msnco_pkg::PHASE_W-1:0]  wr_data,
    input  wire logic                           rd_en,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic      [msnco_pkg::PHASE_W-1:0]  rd_data
);
    import msnco_pkg::*;

    logic [PHASE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : msnco_acc_ram
`default_nettype wire

// ----- hw/rtl/msnco_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msnco_cfg_regs
// Configuration registers, channel count clamping and the clear strobe
// raised when the channel count is written.
// ----------------------------------------------------------------------------
module msnco_cfg_regs #(
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire msnco_pkg::cfg_index_t  cfg_wr_index,
    input  wire msnco_pkg::cfg_data_t   cfg_wr_data,
    output msnco_pkg::cfg_t             cfg,
    output logic                        count_wr
);
    import msnco_pkg::*;

    localparam logic [6:0] MAX_C = 7'(MAX_CHANNELS);

    logic [COUNT_W-1:0] count_reg;
    logic [PHASE_W-1:0] offset_reg;
    logic [PHASE_W-1:0] rate_reg;
    logic               bipolar_reg;
    logic [6:0]         count_lo;
    logic [6:0]         count_eff;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= RST_CHANNEL_COUNT;
            offset_reg  <= RST_CHANNEL_OFFSET;
            rate_reg    <= RST_RATE_SCALE;
            bipolar_reg <= RST_BIPOLAR_MODE;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_CHANNEL_COUNT:  count_reg   <= cfg_wr_data[COUNT_W-1:0];
                REG_CHANNEL_OFFSET: offset_reg  <= cfg_wr_data[PHASE_W-1:0];
                REG_RATE_SCALE:     rate_reg    <= cfg_wr_data[PHASE_W-1:0];
                REG_BIPOLAR_MODE:   bipolar_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // a count write clears every accumulator
    assign count_wr = cfg_wr_en && (cfg_wr_index == REG_CHANNEL_COUNT);

    // active count held to 1..MAX_CHANNELS
    always_comb begin
        count_lo  = (count_reg == '0) ? 7'd1 : 7'(count_reg);
        count_eff = (count_lo > MAX_C) ? MAX_C : count_lo;
    end

    assign cfg.last_ch     = COUNT_W'(count_eff - 7'd1);
    assign cfg.offset_step = offset_reg;
    assign cfg.rate_scale  = rate_reg;
    assign cfg.bipolar     = bipolar_reg;

endmodule : msnco_cfg_regs
`default_nettype wire

// ----- hw/rtl/multichannel_sawtooth_nco.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_sawtooth_nco
// Per-channel phase accumulator sawtooth oscillator. Accumulators live in a
// small synchronous RAM, read on accept, updated and written back two stages
// later, with forwarding between in-flight beats of the same channel.
//
//   port    dir  handshake        payload
//   s_*     in   s_valid/s_ready  channel, frequency, phase_offset, reset_now
//   m_*     out  m_valid/m_ready  sample (Q1.23)
//   cfg_*   in   cfg_wr_en        cfg_wr_index, cfg_wr_data
//
// One beat per cycle sustained while m_ready stays high; each beat passes through
// stage 1 (read/multiply), stage 2 (accumulate) and stage 3 (phase sum into the output register).
// Each stage advances whenever the stage after it is empty or moving, so
// input is taken while a sample waits on m_ready, as long as an earlier stage is empty.
// Reset clears the per-channel valid bits at once: no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_sawtooth_nco #(
    parameter int unsigned MAX_CHANNELS = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input beats
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic        [msnco_pkg::CH_W-1:0]    s_channel,
    input  wire logic signed [msnco_pkg::FREQ_W-1:0]  s_frequency,
    input  wire logic        [msnco_pkg::PHASE_W-1:0] s_phase_offset,
    input  wire logic                                 s_reset_now,
    // output beats
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed      [msnco_pkg::SAMPLE_W-1:0] m_sample,
    // configuration
    input  wire logic                                 cfg_wr_en,
    input  wire msnco_pkg::cfg_index_t                cfg_wr_index,
    input  wire msnco_pkg::cfg_data_t                 cfg_wr_data
);
    import msnco_pkg::*;

    localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned PROD_W = 2 * PHASE_W - 1;

    cfg_t               cfg;
    logic               count_wr;

    // handshake chain
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic               out_take, s3_ready, s2_ready, s1_ready;
    logic               accept, s1_fire, s2_fire, s3_fire;

    // accept-side decode
    logic [COUNT_W-1:0] ch_ext;
    logic [COUNT_W-1:0] ch_sel;
    logic [AW-1:0]      idx_in;

    // stage 1
    logic [CH_W-1:0]    ch1_reg;
    logic [FREQ_W-2:0]  freq1_reg;
    logic [PHASE_W-1:0] poff1_reg;
    logic               rst1_reg;
    logic               rdv1_reg;
    logic               byp1_reg;
    logic [PHASE_W-1:0] bypd1_reg;
    logic [AW-1:0]      idx1;
    logic [PHASE_W-1:0] mem_rd;
    logic [PHASE_W-1:0] base1;
    logic [PHASE_W-1:0] base1_fwd;
    logic [PROD_W-1:0]  inc_prod;
    logic [PHASE_W+CH_W-1:0] choff_prod;

    // stage 2
    logic [AW-1:0]      idx2_reg;
    logic [PHASE_W-1:0] base2_reg;
    logic [PHASE_W-1:0] inc2_reg;
    logic [PHASE_W-1:0] offs2_reg;
    logic [PHASE_W-1:0] acc2;

    // stage 3
    logic [PHASE_W-1:0] acc3_reg;
    logic [PHASE_W-1:0] offs3_reg;
    logic [PHASE_W-1:0] phase3;
    logic [SAMPLE_W-1:0] sample3;

    // output
    logic [SAMPLE_W-1:0] sample_reg;

    // per-channel written flags
    logic [MAX_CHANNELS-1:0] vbits_reg;

    msnco_cfg_regs #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg),
        .count_wr     (count_wr)
    );

    msnco_acc_ram #(
        .DEPTH   (MAX_CHANNELS)
    ) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (s2_fire),
        .wr_addr (idx2_reg),
        .wr_data (acc2),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (mem_rd)
    );

    // stage handshakes: a stage moves when the next is empty or moving
    always_comb begin
        out_take = !out_valid_reg || m_ready;
        s3_ready = !s3_valid_reg || out_take;
        s2_ready = !s2_valid_reg || s3_ready;
        s1_ready = !s1_valid_reg || s2_ready;
        accept   = s_valid && s1_ready;
        s1_fire  = s1_valid_reg && s2_ready;
        s2_fire  = s2_valid_reg && s3_ready;
        s3_fire  = s3_valid_reg && out_take;
    end

    assign s_ready = s1_ready;
    assign m_valid = out_valid_reg;
    assign m_sample = signed'(sample_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg  <= s_valid;
            if (s2_ready) s2_valid_reg  <= s1_valid_reg;
            if (s3_ready) s3_valid_reg  <= s2_valid_reg;
            if (out_take) out_valid_reg <= s3_valid_reg;
        end
    end

    // channel clamp to the last active channel
    always_comb begin
        ch_ext = COUNT_W'(s_channel);
        ch_sel = (ch_ext > cfg.last_ch) ? cfg.last_ch : ch_ext;
        idx_in = AW'(ch_sel);
    end

    // accumulator written flags, cleared by reset and count writes
    always_ff @(posedge aclk) begin
        if (!aresetn || count_wr) begin
            vbits_reg <= '0;
        end else if (s2_fire) begin
            vbits_reg[idx2_reg] <= 1'b1;
        end
    end

    // stage 1 payload, captured on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            ch1_reg   <= ch_sel[CH_W-1:0];
            freq1_reg <= s_frequency[FREQ_W-1] ? '0 : s_frequency[FREQ_W-2:0];
            poff1_reg <= s_phase_offset;
            rst1_reg  <= s_reset_now;
            rdv1_reg  <= vbits_reg[idx_in];
        end
    end

    assign idx1 = AW'(ch1_reg);

    // catch write-backs to this channel that the ram read missed
    always_ff @(posedge aclk) begin
        if (accept) begin
            byp1_reg  <= s2_fire && (idx2_reg == idx_in);
            bypd1_reg <= acc2;
        end else if (s2_fire && (idx2_reg == idx1)) begin
            byp1_reg  <= 1'b1;
            bypd1_reg <= acc2;
        end
    end

    // stage 1: resolve base, form increment and channel offset
    always_comb begin
        base1      = byp1_reg ? bypd1_reg : (rdv1_reg ? mem_rd : '0);
        base1_fwd  = (s2_fire && (idx2_reg == idx1)) ? acc2 : base1;
        inc_prod   = PROD_W'(freq1_reg) * PROD_W'(cfg.rate_scale);
        choff_prod = (PHASE_W+CH_W)'(ch1_reg) * (PHASE_W+CH_W)'(cfg.offset_step);
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            idx2_reg  <= idx1;
            base2_reg <= rst1_reg ? '0 : base1_fwd;
            inc2_reg  <= inc_prod[FREQ_FRAC +: PHASE_W];
            offs2_reg <= choff_prod[PHASE_W-1:0] + poff1_reg;
        end
    end

    // stage 2: accumulate, written back as the beat moves on
    assign acc2 = base2_reg + inc2_reg;

    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            acc3_reg  <= acc2;
            offs3_reg <= offs2_reg;
        end
    end

    // stage 3: output phase and Q1.23 formatting
    always_comb begin
        phase3 = acc3_reg + offs3_reg;
        if (cfg.bipolar) begin
            sample3 = phase3[PHASE_W-1 -: SAMPLE_W] - BIPOLAR_BIAS;
        end else begin
            sample3 = {1'b0, phase3[PHASE_W-1 -: SAMPLE_W-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_fire) begin
            sample_reg <= sample3;
        end
    end

endmodule : multichannel_sawtooth_nco
`default_nettype wire

// ----- tb/multichannel_sawtooth_nco_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_sawtooth_nco_test
// Self-checking bench for the multichannel sawtooth oscillator. It starts with
// a short table of directed frames, then runs random frames under a series of
// register settings. A cycle-free predictor works out each sample not typed in
// the table; every output beat is checked. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module multichannel_sawtooth_nco_test;
    import msnco_pkg::*;

    // one input frame as driven on the s_ channel
    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [FREQ_W-1:0] frequency;
        logic [PHASE_W-1:0]       phase_offset;
        logic                     reset_now;
    } frame_t;

    // directed row: frame plus an optional hand-worked sample
    typedef struct packed {
        frame_t              frame;
        logic                has_sample;
        logic [SAMPLE_W-1:0] sample;
    } dir_row_t;

    localparam int N_DIR       = 16;
    localparam int N_SETTINGS  = 8;
    localparam int PHASE_ITEMS = 105;
    localparam int DRAIN_WAIT  = 8;

    // rows with a typed sample assume the register values after reset
    dir_row_t dir_rows [N_DIR] = '{
        // idle channel right after reset: bottom of the bipolar range
        '{'{3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, 24'h80_0000},
        // largest phase offset: top of the range
        '{'{3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, 1'b1, 24'h7F_FFFF},
        // second channel sits half a cycle ahead
        '{'{3'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, 24'h00_0000},
        // channel past the count folds onto the last one
        '{'{3'd7, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1, 24'h00_0000},
        // negative frequencies hold the accumulator
        '{'{3'd0, 32'h8000_0000, 32'h0000_0000, 1'b0}, 1'b1, 24'h80_0000},
        '{'{3'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0}, 1'b1, 24'h80_0000},
        // largest positive frequency
        '{'{3'd0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0}, 1'b0, 24'h0},
        '{'{3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0, 24'h0},
        // accumulator cleared with no advance
        '{'{3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1, 24'h80_0000},
        '{'{3'd1, 32'h0000_1000, 32'h0000_0000, 1'b0}, 1'b0, 24'h0},
        '{'{3'd5, 32'h0044_0000, 32'h0000_0000, 1'b1}, 1'b0, 24'h0},
        '{'{3'd2, 32'h7FFF_FFFF, 32'h1234_5678, 1'b1}, 1'b0, 24'h0},
        '{'{3'd3, 32'hC000_0000, 32'h0000_0000, 1'b0}, 1'b0, 24'h0},
        '{'{3'd0, 32'h01B8_0000, 32'h0000_0000, 1'b0}, 1'b0, 24'h0},
        // cleared channel one plus offset just under half: full scale
        '{'{3'd1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1}, 1'b1, 24'h7F_FFFF},
        '{'{3'd4, 32'h0000_0001, 32'h0000_0000, 1'b0}, 1'b0, 24'h0}
    };

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [CH_W-1:0]       s_channel      = '0;
    logic signed [FREQ_W-1:0] s_frequency = '0;
    logic [PHASE_W-1:0]    s_phase_offset = '0;
    logic                  s_reset_now    = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                  cfg_wr_en      = 1'b0;
    cfg_index_t            cfg_wr_index   = '0;
    cfg_data_t             cfg_wr_data    = '0;

    // predictor copy of the registers and accumulators
    logic [COUNT_W-1:0]    count_reg;
    logic [PHASE_W-1:0]    step_reg;
    logic [PHASE_W-1:0]    rate_reg;
    logic                  bipolar_reg;
    logic [PHASE_W-1:0]    phase_acc [8];

    logic [SAMPLE_W-1:0]   expected_samples [$];
    int                    fail_count     = 0;
    int                    frames_sent    = 0;
    int                    samples_seen   = 0;
    bit                    rx_no_stall    = 1'b0;
    logic [CH_W-1:0]       last_ch        = '0;

    multichannel_sawtooth_nco u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel      (s_channel),
        .s_frequency    (s_frequency),
        .s_phase_offset (s_phase_offset),
        .s_reset_now    (s_reset_now),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop in case a handshake hangs
    initial begin
        #500_000;
        $display("status: fail");
        $finish;
    end

    function automatic void clear_phase_acc();
        for (int i = 0; i < 8; i++) phase_acc[i] = '0;
    endfunction

    // register write as seen by the predictor
    function automatic void apply_reg(cfg_index_t idx, cfg_data_t data);
        case (idx)
            REG_CHANNEL_COUNT: begin
                count_reg = data[COUNT_W-1:0];
                clear_phase_acc();
            end
            REG_CHANNEL_OFFSET: step_reg    = data;
            REG_RATE_SCALE:     rate_reg    = data;
            REG_BIPOLAR_MODE:   bipolar_reg = data[0];
            default: ;
        endcase
    endfunction

    // advance one channel and return its sawtooth sample
    function automatic logic [SAMPLE_W-1:0] predict_sample(frame_t f);
        int unsigned         n;
        int unsigned         ch;
        logic [63:0]         prod;
        logic [PHASE_W-1:0]  ch_spread;
        logic [PHASE_W-1:0]  phase;
        n = count_reg;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        ch = f.channel;
        if (ch >= n) ch = n - 1;
        if (f.reset_now) phase_acc[ch] = '0;
        // negative frequency holds still
        prod = f.frequency[FREQ_W-1] ? 64'd0
                                     : {32'd0, f.frequency} * {32'd0, rate_reg};
        phase_acc[ch] = phase_acc[ch] + prod[FREQ_FRAC +: PHASE_W];
        ch_spread = PHASE_W'(ch) * step_reg;
        phase = phase_acc[ch] + ch_spread + f.phase_offset;
        if (bipolar_reg) return phase[PHASE_W-1:8] - BIPOLAR_BIAS;
        return {1'b0, phase[PHASE_W-1:9]};
    endfunction

    // random frame, biased toward active channels and audio-range pitches
    function automatic frame_t random_frame();
        frame_t      f;
        int unsigned n;
        int unsigned pick;
        n = (count_reg < 1) ? 1 : (count_reg > 8) ? 8 : count_reg;
        if ($urandom_range(0, 1) == 0) f.channel = last_ch;
        else if ($urandom_range(0, 4) != 0) f.channel = CH_W'($urandom_range(0, n - 1));
        else f.channel = CH_W'($urandom);
        last_ch = f.channel;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: f.frequency = $urandom_range(0, 20000) << FREQ_FRAC;
            3, 4, 5: f.frequency = $urandom & 32'h7FFF_FFFF;
            6, 7:    f.frequency = $urandom;
            8:       f.frequency = $urandom | 32'h8000_0000;
            default: begin
                case ($urandom_range(0, 4))
                    0: f.frequency = 32'h0000_0000;
                    1: f.frequency = 32'h7FFF_FFFF;
                    2: f.frequency = 32'h8000_0000;
                    3: f.frequency = 32'hFFFF_FFFF;
                    default: f.frequency = 32'h0000_0001;
                endcase
            end
        endcase
        case ($urandom_range(0, 9))
            0:       f.phase_offset = '0;
            1:       f.phase_offset = '1;
            default: f.phase_offset = $urandom;
        endcase
        f.reset_now = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    // one register write on the config port
    task automatic write_reg(cfg_index_t idx, cfg_data_t data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        apply_reg(idx, data);
    endtask

    // full register setting, plus a write to an unused index
    task automatic load_setting(logic [COUNT_W-1:0] cnt, cfg_data_t step,
                                cfg_data_t rate, logic bip);
        cfg_data_t junk;
        junk = $urandom;
        write_reg(cfg_index_t'($urandom_range(4, 15)), junk);
        write_reg(REG_CHANNEL_COUNT, {junk[31:COUNT_W], cnt});
        write_reg(REG_CHANNEL_OFFSET, step);
        write_reg(REG_RATE_SCALE, rate);
        write_reg(REG_BIPOLAR_MODE, {junk[31:1], bip});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // drive one frame beat and record its expected sample on accept
    task automatic send_frame(frame_t f, bit use_typed, logic [SAMPLE_W-1:0] typed,
                              bit no_gap);
        int unsigned         gap;
        logic [SAMPLE_W-1:0] pred;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_channel      <= f.channel;
        s_frequency    <= f.frequency;
        s_phase_offset <= f.phase_offset;
        s_reset_now    <= f.reset_now;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = predict_sample(f);
        expected_samples.push_back(use_typed ? typed : pred);
        frames_sent++;
    endtask

    // wait until every sample is back, then let the pipeline settle
    task automatic drain();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // output side: random stalls, compare each beat with the oldest expectation
    initial begin
        int unsigned         stall;
        logic [SAMPLE_W-1:0] exp_s;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_no_stall ? 0 : $urandom_range(0, 8);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            samples_seen++;
            if (expected_samples.size() == 0) begin
                $error("sample beat with nothing expected, got %0d", m_sample);
                fail_count++;
            end else begin
                exp_s = expected_samples.pop_front();
                if (m_sample !== exp_s) begin
                    $error("sample mismatch: expected %0d, got %0d",
                           $signed(exp_s), m_sample);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        bit no_gap;
        count_reg   = RST_CHANNEL_COUNT;
        step_reg    = RST_CHANNEL_OFFSET;
        rate_reg    = RST_RATE_SCALE;
        bipolar_reg = RST_BIPOLAR_MODE;
        clear_phase_acc();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table under the reset setting
        for (int i = 0; i < N_DIR; i++) begin
            send_frame(dir_rows[i].frame, dir_rows[i].has_sample,
                       dir_rows[i].sample, i < 6);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        drain();

        // random frames under each register setting
        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: load_setting(4'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
                1: load_setting(4'd8, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
                2: load_setting(4'd0, $urandom, $urandom, 1'b0);
                3: load_setting(4'd15, $urandom, RST_RATE_SCALE, 1'b1);
                4: load_setting(4'd9, $urandom, $urandom_range(0, 200000), 1'($urandom));
                default: load_setting(COUNT_W'($urandom_range(1, 8)), $urandom,
                                      ($urandom_range(0, 1) ? $urandom
                                                            : $urandom_range(0, 200000)),
                                      1'($urandom));
            endcase
            no_gap      = (p % 3 == 1);
            rx_no_stall = (p % 4 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_frame(random_frame(), 1'b0, '0, no_gap);
            end
            @(negedge aclk);
            s_valid <= 1'b0;
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d frames (%0d directed) over %0d register settings",
                 frames_sent, N_DIR, N_SETTINGS + 1);
        $display("checked %0d samples, %0d failures", samples_seen, fail_count);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            if (expected_samples.size() != 0)
                $error("%0d expected samples never arrived", expected_samples.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule
